[design/crcfd_pkg.sv]
// ----------------------------------------------------------------------------
// crcfd_pkg
// Shared constants, types and the byte-wide CRC step for the frame deframer.
// ----------------------------------------------------------------------------
package crcfd_pkg;

  // frame geometry
  localparam int MAX_DATA = 8;
  localparam int HDR_TRL  = 7;                    // head, type, len x2, crc x2, tail
  localparam int WINDOW   = MAX_DATA + HDR_TRL;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int DLEN_W   = 4;
  localparam int PAY_W    = 64;

  // crc constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indices
  localparam logic CFG_HEAD = 1'b0;
  localparam logic CFG_TAIL = 1'b1;

  // result status codes
  localparam logic [1:0] STS_GOOD = 2'd0;
  localparam logic [1:0] STS_LEN  = 2'd1;
  localparam logic [1:0] STS_CRC  = 2'd2;
  localparam logic [1:0] STS_TAIL = 2'd3;

  // window control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
  } win_ctrl_t;

  // crc unit control
  typedef struct packed {
    logic init;
    logic step;
  } crc_ctrl_t;

  // one result item
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        frame_type;
    logic [DLEN_W-1:0] data_len;
    logic [PAY_W-1:0]  payload;
  } result_t;

  // reflected crc-16 over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/crcfd_window.sv]
// ----------------------------------------------------------------------------
// crcfd_window
// Byte window: appends at the fill level, drops the front byte by shifting,
// one indexed read port plus the whole window for fixed-position reads.
// ----------------------------------------------------------------------------
module crcfd_window (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  crcfd_pkg::win_ctrl_t                ctrl_i,
  input  logic [7:0]                          wr_byte_i,
  input  logic [crcfd_pkg::IDX_W-1:0]         rd_idx_i,
  output logic [7:0]                          rd_byte_o,
  output logic [crcfd_pkg::FILL_W-1:0]        fill_o,
  output logic [crcfd_pkg::WINDOW*8-1:0]      bytes_o
);
  import crcfd_pkg::*;

  logic [7:0]        mem_q [WINDOW];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              can_push;

  assign can_push = (fill_q < FILL_W'(WINDOW));

  // byte storage: append or shift down by one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && can_push) begin
      mem_q[fill_q[IDX_W-1:0]] <= wr_byte_i;
    end else if (ctrl_i.pop) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        mem_q[j] <= mem_q[j+1];
      end
    end
  end

  // fill level
  always_comb begin
    fill_d = fill_q;
    if (ctrl_i.push && can_push) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (ctrl_i.pop && (fill_q != '0)) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // read side
  assign rd_byte_o = mem_q[rd_idx_i];
  assign fill_o    = fill_q;

  for (genvar g = 0; g < WINDOW; g++) begin : g_bytes
    assign bytes_o[8*g +: 8] = mem_q[g];
  end

endmodule

[design/crcfd_crc.sv]
// ----------------------------------------------------------------------------
// crcfd_crc
// Crc-16 unit: folds one payload byte per stepped cycle into a running value.
// ----------------------------------------------------------------------------
module crcfd_crc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crcfd_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  output logic [15:0]          crc_o
);
  import crcfd_pkg::*;

  logic [15:0] crc_q, crc_d;

  // seed or advance the running crc
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.step) begin
      crc_d = crc_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

[design/crc16_frame_deframer.sv]
// ----------------------------------------------------------------------------
// crc16_frame_deframer
// Flow: a byte that completes no decision passes through S_SCAN and S_FIN
// before the next transfer; one dropped while hunting is taken without leaving
// S_IDLE. A frame check does one crc step per payload byte through the crc
// unit, then checks both crc bytes and the tail; a good frame is then dropped
// from the window byte by byte in S_DROP. Result stalls can hold the sequencer.
// Reset empties the window, restores head 0xAA and tail 0x55.
// ----------------------------------------------------------------------------
module crc16_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  // byte input
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // results
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [1:0]                    status_o,
  output logic [7:0]                    frame_type_o,
  output logic [crcfd_pkg::DLEN_W-1:0]  data_len_o,
  output logic [crcfd_pkg::PAY_W-1:0]   payload_o,
  output logic                          last_o
);
  import crcfd_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CRC  = 3'd2;
  localparam logic [2:0] S_CKH  = 3'd3;
  localparam logic [2:0] S_CKL  = 3'd4;
  localparam logic [2:0] S_CKT  = 3'd5;
  localparam logic [2:0] S_DROP = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [7:0]           head_q, tail_q;
  logic [IDX_W-1:0]     rd_q, rd_d;
  logic [FILL_W-1:0]    drop_q, drop_d;
  logic                 hi_ok_q, hi_ok_d;
  logic                 crc_ok_q, crc_ok_d;

  logic                 pend_v_q, pend_v_d;
  result_t              pend_q, pend_d;
  logic                 out_v_q, out_v_d;
  result_t              out_q, out_d;
  logic                 out_last_q, out_last_d;

  win_ctrl_t            win_ctrl;
  crc_ctrl_t            crc_ctrl;
  logic [7:0]           rd_byte;
  logic [FILL_W-1:0]    fill;
  logic [WINDOW*8-1:0]  win;
  logic [15:0]          crc;

  logic                 rx_xfer;
  logic [15:0]          len16;
  logic                 len_bad;
  logic [DLEN_W-1:0]    len;
  logic [4:0]           total;
  logic [IDX_W-1:0]     crc_end;
  logic [PAY_W-1:0]     pay;
  logic                 out_free;
  logic                 can_emit;
  logic                 emit;
  result_t              new_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 8'hAA;
      tail_q <= 8'h55;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEAD: head_q <= cfg_wdata_i;
        CFG_TAIL: tail_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  crcfd_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (win_ctrl),
    .wr_byte_i (rx_byte_i),
    .rd_idx_i  (rd_q),
    .rd_byte_o (rd_byte),
    .fill_o    (fill),
    .bytes_o   (win)
  );

  crcfd_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (rd_byte),
    .crc_o  (crc)
  );

  // header fields at fixed window positions
  assign len16   = {win[8*2 +: 8], win[8*3 +: 8]};
  assign len_bad = (len16 > 16'(MAX_DATA));
  assign len     = len16[DLEN_W-1:0];
  assign total   = 5'(HDR_TRL) + 5'(len);
  assign crc_end = IDX_W'(4) + IDX_W'(len);

  // payload bytes, unused lanes zero
  always_comb begin
    pay = '0;
    for (int i = 0; i < MAX_DATA; i++) begin
      if (DLEN_W'(i) < len) begin
        pay[8*i +: 8] = win[8*(4+i) +: 8];
      end
    end
  end

  assign rx_ready_o = (state_q == S_IDLE);
  assign rx_xfer    = rx_valid_i && rx_ready_o;
  assign out_free   = !out_v_q || res_ready_i;
  assign can_emit   = !pend_v_q || out_free;

  // sequencer
  always_comb begin
    state_d       = state_q;
    rd_d          = rd_q;
    drop_d        = drop_q;
    hi_ok_d       = hi_ok_q;
    crc_ok_d      = crc_ok_q;
    win_ctrl      = '0;
    crc_ctrl      = '0;
    emit          = 1'b0;
    new_res       = '0;

    case (state_q)
      S_IDLE: begin
        if (rx_xfer && ((fill != '0) || (rx_byte_i == head_q))) begin
          win_ctrl.push = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if ((fill != '0) && (win[7:0] != head_q)) begin
          win_ctrl.pop = 1'b1;
        end else if (fill < FILL_W'(HDR_TRL)) begin
          state_d = S_FIN;
        end else if (len_bad) begin
          if (can_emit) begin
            emit           = 1'b1;
            new_res.status = STS_LEN;
            win_ctrl.pop   = 1'b1;
          end
        end else if (5'(fill) < total) begin
          state_d = S_FIN;
        end else begin
          crc_ctrl.init = 1'b1;
          rd_d          = IDX_W'(4);
          state_d       = S_CRC;
        end
      end
      S_CRC: begin
        if (rd_q == crc_end) begin
          state_d = S_CKH;
        end else begin
          crc_ctrl.step = 1'b1;
          rd_d          = rd_q + IDX_W'(1);
        end
      end
      S_CKH: begin
        hi_ok_d = (rd_byte == crc[15:8]);
        rd_d    = rd_q + IDX_W'(1);
        state_d = S_CKL;
      end
      S_CKL: begin
        crc_ok_d = hi_ok_q && (rd_byte == crc[7:0]);
        rd_d     = rd_q + IDX_W'(1);
        state_d  = S_CKT;
      end
      S_CKT: begin
        if (can_emit) begin
          emit               = 1'b1;
          new_res.frame_type = win[8*1 +: 8];
          if (!crc_ok_q) begin
            new_res.status = STS_CRC;
            win_ctrl.pop   = 1'b1;
            state_d        = S_SCAN;
          end else if (rd_byte != tail_q) begin
            new_res.status = STS_TAIL;
            win_ctrl.pop   = 1'b1;
            state_d        = S_SCAN;
          end else begin
            new_res.status   = STS_GOOD;
            new_res.data_len = len;
            new_res.payload  = pay;
            drop_d           = FILL_W'(total);
            state_d          = S_DROP;
          end
        end
      end
      S_DROP: begin
        win_ctrl.pop = 1'b1;
        drop_d       = drop_q - FILL_W'(1);
        if (drop_q == FILL_W'(1)) begin
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        if (!pend_v_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // pending result and output register: the held result learns its last
  // flag once the next result or the end of the byte is known
  always_comb begin
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !res_ready_i;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (emit) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d   = new_res;
    end else if ((state_q == S_FIN) && pend_v_q && out_free) begin
      out_v_d    = 1'b1;
      out_d      = pend_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_q     <= '0;
      drop_q   <= '0;
      hi_ok_q  <= 1'b0;
      crc_ok_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_q     <= rd_d;
      drop_q   <= drop_d;
      hi_ok_q  <= hi_ok_d;
      crc_ok_q <= crc_ok_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign res_valid_o  = out_v_q;
  assign status_o     = out_q.status;
  assign frame_type_o = out_q.frame_type;
  assign data_len_o   = out_q.data_len;
  assign payload_o    = out_q.payload;
  assign last_o       = out_last_q;

endmodule
